### sv/adfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package adfp_pkg;

   localparam logic [7:0] CHAR_START = 8'h73;
   localparam logic [7:0] CHAR_END   = 8'h65;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [4:0] END_POS   = 5'd18;
   localparam logic [4:0] FRAME_LEN = 5'd19;

   // field numbers, also the bit of each field in the stopped mask
   localparam logic [1:0] FIELD_DEVICE    = 2'd0;
   localparam logic [1:0] FIELD_PWM       = 2'd1;
   localparam logic [1:0] FIELD_SENSOR    = 2'd2;
   localparam logic [1:0] FIELD_THRESHOLD = 2'd3;

   localparam int DEVICE_W    = 7;
   localparam int PWM_W       = 10;
   localparam int SENSOR_W    = 14;
   localparam int THRESHOLD_W = 10;

   localparam int RSP_DATA_W = 56;

   typedef struct packed {
      logic [4:0]             byte_position;
      logic                   started_with_s;
      logic                   overrun;
      logic [DEVICE_W-1:0]    device_acc;
      logic [PWM_W-1:0]       pwm_acc;
      logic [SENSOR_W-1:0]    sensor_acc;
      logic [THRESHOLD_W-1:0] threshold_acc;
      logic [3:0]             field_stopped;
   } frame_state_type;

   typedef struct packed {
      logic [7:0]             echo_byte;
      logic                   frame_done;
      logic                   frame_ok;
      logic [DEVICE_W-1:0]    device_id;
      logic [PWM_W-1:0]       pwm_level;
      logic [SENSOR_W-1:0]    sensor_reading;
      logic [THRESHOLD_W-1:0] threshold_level;
   } frame_result_type;

endpackage

`default_nettype wire

### sv/adfp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module adfp_step (
   input  wire logic [7:0]               rx_byte,
   input  wire adfp_pkg::frame_state_type cur_state,
   output adfp_pkg::frame_state_type      nxt_state,
   output adfp_pkg::frame_result_type     result
);

   logic       in_field;
   logic [1:0] field_sel;
   logic       is_digit;
   logic [3:0] digit;

   assign is_digit = (rx_byte >= adfp_pkg::CHAR_ZERO) && (rx_byte <= adfp_pkg::CHAR_NINE);
   assign digit    = rx_byte[3:0];

   // map position to its decimal field
   always_comb begin
      in_field  = 1'b1;
      field_sel = adfp_pkg::FIELD_DEVICE;
      case (cur_state.byte_position) inside
         [5'd2:5'd3]:   field_sel = adfp_pkg::FIELD_DEVICE;
         [5'd5:5'd7]:   field_sel = adfp_pkg::FIELD_PWM;
         [5'd9:5'd12]:  field_sel = adfp_pkg::FIELD_SENSOR;
         [5'd14:5'd16]: field_sel = adfp_pkg::FIELD_THRESHOLD;
         default:       in_field  = 1'b0;
      endcase
   end

   always_comb begin
      nxt_state        = cur_state;
      result           = '0;
      result.echo_byte = rx_byte;
      if (rx_byte == adfp_pkg::CHAR_START) begin
         nxt_state                = '0;
         nxt_state.started_with_s = 1'b1;
         nxt_state.byte_position  = 5'd1;
      end else if (rx_byte == adfp_pkg::CHAR_END) begin
         result.frame_done = 1'b1;
         if (cur_state.started_with_s && !cur_state.overrun &&
             (cur_state.byte_position == adfp_pkg::END_POS)) begin
            result.frame_ok        = 1'b1;
            result.device_id       = cur_state.device_acc;
            result.pwm_level       = cur_state.pwm_acc;
            result.sensor_reading  = cur_state.sensor_acc;
            result.threshold_level = cur_state.threshold_acc;
         end
         nxt_state = '0;
      end else if (cur_state.byte_position >= adfp_pkg::FRAME_LEN) begin
         // drop the byte and hold the counter saturated
         nxt_state.byte_position = adfp_pkg::FRAME_LEN;
         nxt_state.overrun       = 1'b1;
      end else begin
         if (cur_state.byte_position == 5'd0) begin
            nxt_state.started_with_s = 1'b0;
         end
         if (in_field && !cur_state.field_stopped[field_sel]) begin
            if (!is_digit) begin
               nxt_state.field_stopped[field_sel] = 1'b1;
            end else begin
               // acc * 10 + digit, wrapped to the field width
               case (field_sel)
                  adfp_pkg::FIELD_DEVICE: nxt_state.device_acc =
                     {cur_state.device_acc[3:0], 3'b000} +
                     {cur_state.device_acc[5:0], 1'b0} + {3'b000, digit};
                  adfp_pkg::FIELD_PWM: nxt_state.pwm_acc =
                     {cur_state.pwm_acc[6:0], 3'b000} +
                     {cur_state.pwm_acc[8:0], 1'b0} + {6'b0, digit};
                  adfp_pkg::FIELD_SENSOR: nxt_state.sensor_acc =
                     {cur_state.sensor_acc[10:0], 3'b000} +
                     {cur_state.sensor_acc[12:0], 1'b0} + {10'b0, digit};
                  default: nxt_state.threshold_acc =
                     {cur_state.threshold_acc[6:0], 3'b000} +
                     {cur_state.threshold_acc[8:0], 1'b0} + {6'b0, digit};
               endcase
            end
         end
         nxt_state.byte_position = cur_state.byte_position + 5'd1;
      end
   end

endmodule

`default_nettype wire

### sv/ascii_decimal_frame_parser.sv
// A byte on req_tdata passes through the input register and then the result register
// before its result appears on rsp_; an rsp_tready stall holds both.
// Throughput: one byte per cycle; the input register and the result register
// each take a new transfer whenever the stage after them moves on.
// Reset: synchronous, active high; clears both valid flags and the frame state
// (position, start flag, overrun flag, accumulators and stopped mask).
`timescale 1ns / 1ps
`default_nettype none

module ascii_decimal_frame_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,  // rx_byte
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // echo_byte, device_id, pwm_level, sensor_reading, threshold_level, zero fill
   output logic [adfp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,  // frame_done
   output logic                                 rsp_tuser   // frame_ok
);

   logic                       in_valid_ff;
   logic [7:0]                 in_byte_ff;
   logic                       out_valid_ff;
   adfp_pkg::frame_result_type out_res_ff;
   adfp_pkg::frame_result_type out_res_in;
   adfp_pkg::frame_state_type  state_ff;
   adfp_pkg::frame_state_type  state_in;
   logic                       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   adfp_step u_step (
      .rx_byte   (in_byte_ff),
      .cur_state (state_ff),
      .nxt_state (state_in),
      .result    (out_res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_res_ff <= out_res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_res_ff.frame_done;
   assign rsp_tuser  = out_res_ff.frame_ok;
   assign rsp_tdata  = {7'b0,
                        out_res_ff.threshold_level,
                        out_res_ff.sensor_reading,
                        out_res_ff.pwm_level,
                        out_res_ff.device_id,
                        out_res_ff.echo_byte};

endmodule

`default_nettype wire

### dv/frame_checker.sv
`timescale 1ns / 1ps

module frame_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [adfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                            rsp_tlast,
   input  wire logic                            rsp_tuser,
   output int                                   failures,
   output int                                   pending
);

   // field offsets inside rsp_tdata
   localparam int ECHO_LSB      = 0;
   localparam int DEVICE_LSB    = 8;
   localparam int PWM_LSB       = DEVICE_LSB + adfp_pkg::DEVICE_W;
   localparam int SENSOR_LSB    = PWM_LSB + adfp_pkg::PWM_W;
   localparam int THRESHOLD_LSB = SENSOR_LSB + adfp_pkg::SENSOR_W;
   localparam int FILL_LSB      = THRESHOLD_LSB + adfp_pkg::THRESHOLD_W;

   logic [4:0]                       position;
   logic                             started;
   logic                             overflowed;
   logic [adfp_pkg::DEVICE_W-1:0]    device_sum;
   logic [adfp_pkg::PWM_W-1:0]       pwm_sum;
   logic [adfp_pkg::SENSOR_W-1:0]    sensor_sum;
   logic [adfp_pkg::THRESHOLD_W-1:0] threshold_sum;
   logic [3:0]                       stopped_mask;

   adfp_pkg::frame_result_type expected_results[$];

   function automatic void clear_frame();
      position      = '0;
      started       = 1'b0;
      overflowed    = 1'b0;
      device_sum    = '0;
      pwm_sum       = '0;
      sensor_sum    = '0;
      threshold_sum = '0;
      stopped_mask  = '0;
   endfunction

   function automatic void add_digit(input logic [4:0] pos, input logic [7:0] rx);
      logic [1:0] field;
      logic       in_field;
      logic [3:0] digit;
      in_field = 1'b1;
      field    = adfp_pkg::FIELD_DEVICE;
      case (pos) inside
         [5'd2:5'd3]:   field = adfp_pkg::FIELD_DEVICE;
         [5'd5:5'd7]:   field = adfp_pkg::FIELD_PWM;
         [5'd9:5'd12]:  field = adfp_pkg::FIELD_SENSOR;
         [5'd14:5'd16]: field = adfp_pkg::FIELD_THRESHOLD;
         default:       in_field = 1'b0;
      endcase
      if (!in_field || stopped_mask[field]) return;
      if (rx < adfp_pkg::CHAR_ZERO || rx > adfp_pkg::CHAR_NINE) begin
         stopped_mask[field] = 1'b1;
         return;
      end
      digit = 4'(rx - adfp_pkg::CHAR_ZERO);
      case (field)
         adfp_pkg::FIELD_DEVICE:
            device_sum = adfp_pkg::DEVICE_W'(device_sum * 10 + digit);
         adfp_pkg::FIELD_PWM:
            pwm_sum = adfp_pkg::PWM_W'(pwm_sum * 10 + digit);
         adfp_pkg::FIELD_SENSOR:
            sensor_sum = adfp_pkg::SENSOR_W'(sensor_sum * 10 + digit);
         default:
            threshold_sum = adfp_pkg::THRESHOLD_W'(threshold_sum * 10 + digit);
      endcase
   endfunction

   function automatic adfp_pkg::frame_result_type parse_byte(input logic [7:0] rx);
      adfp_pkg::frame_result_type res;
      res           = '0;
      res.echo_byte = rx;
      if (rx == adfp_pkg::CHAR_START) begin
         clear_frame();
         started  = 1'b1;
         position = 5'd1;
      end else if (rx == adfp_pkg::CHAR_END) begin
         res.frame_done = 1'b1;
         if (started && !overflowed && position == adfp_pkg::END_POS) begin
            res.frame_ok        = 1'b1;
            res.device_id       = device_sum;
            res.pwm_level       = pwm_sum;
            res.sensor_reading  = sensor_sum;
            res.threshold_level = threshold_sum;
         end
         clear_frame();
      end else if (position >= adfp_pkg::FRAME_LEN) begin
         // drop the byte and mark the frame as overrun
         position   = adfp_pkg::FRAME_LEN;
         overflowed = 1'b1;
      end else begin
         if (position == 5'd0) started = 1'b0;
         add_digit(position, rx);
         position = position + 5'd1;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      adfp_pkg::frame_result_type want;
      if (reset) begin
         clear_frame();
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(parse_byte(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing expected: tdata %h", rsp_tdata);
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("echo_byte", want.echo_byte, rsp_tdata[ECHO_LSB +: 8]);
               check_field("frame_done", want.frame_done, rsp_tlast);
               check_field("frame_ok", want.frame_ok, rsp_tuser);
               check_field("device_id", want.device_id,
                           rsp_tdata[DEVICE_LSB +: adfp_pkg::DEVICE_W]);
               check_field("pwm_level", want.pwm_level,
                           rsp_tdata[PWM_LSB +: adfp_pkg::PWM_W]);
               check_field("sensor_reading", want.sensor_reading,
                           rsp_tdata[SENSOR_LSB +: adfp_pkg::SENSOR_W]);
               check_field("threshold_level", want.threshold_level,
                           rsp_tdata[THRESHOLD_LSB +: adfp_pkg::THRESHOLD_W]);
               check_field("zero fill", 0, rsp_tdata[adfp_pkg::RSP_DATA_W-1:FILL_LSB]);
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam int         TOTAL_BYTES = 740;
   localparam int         PHASE1_AT   = 272;
   localparam int         PHASE2_AT   = 522;
   localparam int         HOLD_AT     = 560;
   localparam int         HOLD_CYCLES = 64;
   localparam int         DRAIN_LIMIT = 20000;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = 8'h00;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [adfp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;

   int failures;
   int pending;
   int sent_bytes  = 0;
   int tx_idle_pct = 38;
   int rx_idle_pct = 59;

   logic [7:0] frame_bytes[$];

   ascii_decimal_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   frame_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

   // any byte except the frame start and end markers
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == adfp_pkg::CHAR_START || b == adfp_pkg::CHAR_END);
      return b;
   endfunction

   function automatic void append_frame(input bit all_nines);
      frame_bytes.push_back(adfp_pkg::CHAR_START);
      for (int pos = 1; pos < adfp_pkg::END_POS; pos++) begin
         case (pos)
            1, 4, 8, 13, 17: begin
               if (!all_nines && $urandom_range(0, 9) == 0)
                  frame_bytes.push_back(plain_byte());
               else
                  frame_bytes.push_back(CHAR_COLON);
            end
            default: begin
               if (all_nines)
                  frame_bytes.push_back(adfp_pkg::CHAR_NINE);
               else if ($urandom_range(0, 19) == 0)
                  frame_bytes.push_back(plain_byte());
               else
                  frame_bytes.push_back(adfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
         endcase
      end
      frame_bytes.push_back(adfp_pkg::CHAR_END);
   endfunction

   task automatic send_byte(input logic [7:0] value);
      if (sent_bytes < PHASE1_AT) begin
         tx_idle_pct = 38;
         rx_idle_pct = 59;
      end else if (sent_bytes < PHASE2_AT) begin
         tx_idle_pct = 59;
         rx_idle_pct = 38;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock);
      while (!req_tready);
      sent_bytes++;
   endtask

   task automatic send_queued();
      while (frame_bytes.size() != 0)
         send_byte(frame_bytes.pop_front());
   endtask

   // receiver: random stalls, plus one long hold-off to back the block up
   initial begin : receiver
      int  hold_left;
      bit  held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sent_bytes >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   initial begin : stimulus
      int kind;
      int keep;
      int extra;
      int drain_cycles;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // largest values in every field, then an end marker with no frame open
      append_frame(1'b1);
      frame_bytes.push_back(adfp_pkg::CHAR_END);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'hFF);
      send_queued();

      while (sent_bytes < TOTAL_BYTES) begin
         kind = $urandom_range(0, 99);
         if (kind < 62) begin
            append_frame(1'b0);
         end else if (kind < 70) begin
            // end marker too early
            append_frame(1'b0);
            keep = $urandom_range(1, 17);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
            frame_bytes.push_back(adfp_pkg::CHAR_END);
         end else if (kind < 78) begin
            // end marker too late, running into the overrun when more than one byte is added
            append_frame(1'b0);
            void'(frame_bytes.pop_back());
            extra = $urandom_range(1, 4);
            repeat (extra) frame_bytes.push_back(plain_byte());
            frame_bytes.push_back(adfp_pkg::CHAR_END);
         end else if (kind < 84) begin
            // no start marker at position 0
            append_frame(1'b0);
            frame_bytes[0] = plain_byte();
         end else if (kind < 92) begin
            // restart part-way through a frame
            append_frame(1'b0);
            keep = $urandom_range(1, 12);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
            append_frame(1'b0);
         end else begin
            repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         send_queued();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      drain_cycles = 0;
      while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (pending != 0) begin
         $display("testbench: errors");
         $finish;
      end else begin
         repeat (10) @(posedge clock);
         if (failures == 0 && pending == 0)
            $display("testbench: clean");
         else
            $display("testbench: errors");
         $finish;
      end
   end

endmodule
